[src/lgme_pkg.sv]
// ----------------------------------------------------------------------------
// lgme_pkg
// Shared types, codes and the cell update rule for the Life grid engine.
// ----------------------------------------------------------------------------
package lgme_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned GEN_W = 16;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RW_EXE,
    ST_ADV_RD,
    ST_ADV_CELL,
    ST_ADV_WR,
    ST_ADV_ZERO,
    ST_DONE
  } state_e;

  // 3x3 neighborhood, row-major, center at bit 4
  typedef logic [8:0] nbhd_t;

  function automatic logic life_next(nbhd_t nb);
    logic [3:0] n;
    logic       nxt;
    n = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n = n + {3'd0, nb[i]};
    end
    case (n)
      4'd2:    nxt = nb[4];
      4'd3:    nxt = 1'b1;
      default: nxt = 1'b0;
    endcase
    return nxt;
  endfunction

endpackage

[src/lgme_in_if.sv]
// ----------------------------------------------------------------------------
// lgme_in_if
// Request channel: cell write, cell read or generation advance.
// ----------------------------------------------------------------------------
interface lgme_in_if;
  logic                              valid;
  logic                              ready;
  logic [lgme_pkg::FUNC_W-1:0]       func;
  logic [lgme_pkg::COORD_W-1:0]      row;
  logic [lgme_pkg::COORD_W-1:0]      col;
  logic                              alive_in;

  modport source (output valid, func, row, col, alive_in, input ready);
  modport sink   (input valid, func, row, col, alive_in, output ready);
endinterface

[src/lgme_out_if.sv]
// ----------------------------------------------------------------------------
// lgme_out_if
// Result channel: cell value and generation count.
// ----------------------------------------------------------------------------
interface lgme_out_if;
  logic                            valid;
  logic                            ready;
  logic                            alive_out;
  logic [lgme_pkg::GEN_W-1:0]      generation;

  modport source (output valid, alive_out, generation, input ready);
  modport sink   (input valid, alive_out, generation, output ready);
endinterface

[src/life_generation_mirror_edges.sv]
// ----------------------------------------------------------------------------
// life_generation_mirror_edges
// Game of Life grid with mirrored edges, two banks of row-wide storage.
// ----------------------------------------------------------------------------
// Write and read: executed in ST_RW_EXE, result loaded into the output register
//   in ST_DONE, one item at a time.
// Advance: for an R x C grid, one shared cell-update unit evaluates one cell
//   per cycle, rows fetched through the single memory read port (3 reads per
//   row); memory rows beyond R are then written with zeros.
// Reset: a clearing pass writes every row of both banks, with no request
//   accepted meanwhile.
module life_generation_mirror_edges #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lgme_in_if.sink                       in_i,
  lgme_out_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgme_pkg::APB_AW-1:0]   paddr,
  input  logic [lgme_pkg::APB_DW-1:0]   pwdata,
  output logic [lgme_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CB = $clog2(MAX_COLS);
  localparam int unsigned AW = RW + 1;
  localparam int unsigned SW = lgme_pkg::SIZE_W;

  // storage: one row of cells per word, address {bank, row}
  logic [MAX_COLS-1:0] mem_q [2**AW];
  logic [MAX_COLS-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata;

  lgme_pkg::state_e state_q, state_d;

  logic [SW-1:0]       cfg_rows_q, cfg_cols_q;
  logic [SW-1:0]       rows_eff, cols_eff;
  logic [AW-1:0]       clr_q, clr_d;
  logic [RW-1:0]       r_q, r_d, r_up, r_dn;
  logic [CB-1:0]       c_q, c_d, c_lf, c_rt;
  logic [1:0]          k_q, k_d;
  logic [MAX_COLS-1:0] win_q [3];
  logic [MAX_COLS-1:0] win_d [3];
  logic [MAX_COLS-1:0] nrow_q, nrow_d;
  logic [MAX_COLS-1:0] wrow;
  lgme_pkg::func_e     req_func_q;
  logic [lgme_pkg::COORD_W-1:0] req_row_q, req_col_q;
  logic                req_alive_q;
  logic                alive_q, alive_d;
  logic                bank_q, bank_d;
  logic [lgme_pkg::GEN_W-1:0] gen_q, gen_d;
  logic                out_valid_q, out_valid_d;
  logic                out_alive_q;
  logic [lgme_pkg::GEN_W-1:0] out_gen_q;
  logic                out_load;
  logic                in_acc, cfg_we, in_grid;
  logic                r_last_grid, r_last_mem, c_last;
  lgme_pkg::nbhd_t     nb;

  // ---------------- configuration ----------------
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lgme_pkg::REG_COLS) ?
                  {{(lgme_pkg::APB_DW-SW){1'b0}}, cfg_cols_q} :
                  {{(lgme_pkg::APB_DW-SW){1'b0}}, cfg_rows_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows_q <= SW'(64);
      cfg_cols_q <= SW'(64);
    end else if (cfg_we) begin
      if (paddr[2] == lgme_pkg::REG_COLS) cfg_cols_q <= pwdata[SW-1:0];
      else cfg_rows_q <= pwdata[SW-1:0];
    end
  end

  // saturate to 2..MAX
  assign rows_eff = (cfg_rows_q < SW'(2)) ? SW'(2) :
                    (32'(cfg_rows_q) > MAX_ROWS) ? SW'(MAX_ROWS) : cfg_rows_q;
  assign cols_eff = (cfg_cols_q < SW'(2)) ? SW'(2) :
                    (32'(cfg_cols_q) > MAX_COLS) ? SW'(MAX_COLS) : cfg_cols_q;

  // ---------------- sweep position ----------------
  assign r_last_grid = (32'(r_q) + 32'd1) == 32'(rows_eff);
  assign r_last_mem  = r_q == RW'(MAX_ROWS - 1);
  assign c_last      = (32'(c_q) + 32'd1) == 32'(cols_eff);
  assign r_up = (r_q == '0) ? r_q : r_q - RW'(1);
  assign r_dn = r_last_grid ? r_q : r_q + RW'(1);
  assign c_lf = (c_q == '0) ? c_q : c_q - CB'(1);
  assign c_rt = c_last ? c_q : c_q + CB'(1);

  assign nb = {win_q[2][c_rt], win_q[2][c_q], win_q[2][c_lf],
               win_q[1][c_rt], win_q[1][c_q], win_q[1][c_lf],
               win_q[0][c_rt], win_q[0][c_q], win_q[0][c_lf]};

  assign in_grid = (32'(req_row_q) < 32'(rows_eff)) && (32'(req_col_q) < 32'(cols_eff));

  assign in_acc     = in_i.valid & in_i.ready;
  assign in_i.ready = state_q == lgme_pkg::ST_IDLE;
  assign out_load   = (state_q == lgme_pkg::ST_DONE) && (!out_valid_q || res_o.ready);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      lgme_pkg::ST_CLEAR: if (&clr_q) state_d = lgme_pkg::ST_IDLE;
      lgme_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (lgme_pkg::func_e'(in_i.func))
            lgme_pkg::FUNC_WRITE,
            lgme_pkg::FUNC_READ:    state_d = lgme_pkg::ST_RW_EXE;
            lgme_pkg::FUNC_ADVANCE: state_d = lgme_pkg::ST_ADV_RD;
            default:                state_d = lgme_pkg::ST_DONE;
          endcase
        end
      end
      lgme_pkg::ST_RW_EXE:   state_d = lgme_pkg::ST_DONE;
      lgme_pkg::ST_ADV_RD:   if (k_q == 2'd3) state_d = lgme_pkg::ST_ADV_CELL;
      lgme_pkg::ST_ADV_CELL: if (c_last) state_d = lgme_pkg::ST_ADV_WR;
      lgme_pkg::ST_ADV_WR: begin
        if (!r_last_grid) state_d = lgme_pkg::ST_ADV_RD;
        else if (r_last_mem) state_d = lgme_pkg::ST_DONE;
        else state_d = lgme_pkg::ST_ADV_ZERO;
      end
      lgme_pkg::ST_ADV_ZERO: if (r_last_mem) state_d = lgme_pkg::ST_DONE;
      lgme_pkg::ST_DONE:     if (out_load) state_d = lgme_pkg::ST_IDLE;
      default:               state_d = lgme_pkg::ST_CLEAR;
    endcase
  end

  // ---------------- datapath and memory control ----------------
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = {~bank_q, r_q};
    mem_raddr   = {bank_q, r_q};
    mem_wdata   = '0;
    clr_d       = clr_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    win_d       = win_q;
    nrow_d      = nrow_q;
    alive_d     = alive_q;
    bank_d      = bank_q;
    gen_d       = gen_q;
    out_valid_d = out_valid_q;
    wrow        = rdata_q;
    wrow[CB'(req_col_q)] = req_alive_q;

    if (res_o.ready) out_valid_d = 1'b0;

    case (state_q)
      lgme_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      lgme_pkg::ST_IDLE: begin
        // row fetch for a cell access; harmless for the other codes
        mem_re    = in_acc;
        mem_raddr = {bank_q, RW'(in_i.row)};
        alive_d   = 1'b0;
        r_d       = '0;
        k_d       = '0;
      end
      lgme_pkg::ST_RW_EXE: begin
        if (req_func_q == lgme_pkg::FUNC_WRITE) begin
          mem_we    = in_grid;
          mem_waddr = {bank_q, RW'(req_row_q)};
          mem_wdata = wrow;
        end else begin
          alive_d = in_grid & rdata_q[CB'(req_col_q)];
        end
      end
      lgme_pkg::ST_ADV_RD: begin
        mem_re = k_q != 2'd3;
        case (k_q)
          2'd0:    mem_raddr = {bank_q, r_up};
          2'd1:    mem_raddr = {bank_q, r_q};
          default: mem_raddr = {bank_q, r_dn};
        endcase
        if (k_q != 2'd0) win_d[k_q - 2'd1] = rdata_q;
        k_d    = k_q + 2'd1;
        c_d    = '0;
        nrow_d = '0;
      end
      lgme_pkg::ST_ADV_CELL: begin
        nrow_d[c_q] = lgme_pkg::life_next(nb);
        c_d         = c_q + CB'(1);
      end
      lgme_pkg::ST_ADV_WR,
      lgme_pkg::ST_ADV_ZERO: begin
        mem_we    = 1'b1;
        mem_wdata = (state_q == lgme_pkg::ST_ADV_WR) ? nrow_q : '0;
        k_d       = '0;
        if (state_d == lgme_pkg::ST_DONE) begin
          bank_d = ~bank_q;
          gen_d  = gen_q + lgme_pkg::GEN_W'(1);
        end else begin
          r_d = r_q + RW'(1);
        end
      end
      lgme_pkg::ST_DONE: if (out_load) out_valid_d = 1'b1;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgme_pkg::ST_CLEAR;
      clr_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      alive_q     <= 1'b0;
      bank_q      <= 1'b0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      alive_q     <= alive_d;
      bank_q      <= bank_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    nrow_q <= nrow_d;
    if (in_acc) begin
      req_func_q  <= lgme_pkg::func_e'(in_i.func);
      req_row_q   <= in_i.row;
      req_col_q   <= in_i.col;
      req_alive_q <= in_i.alive_in;
    end
    if (out_load) begin
      out_alive_q <= alive_q;
      out_gen_q   <= gen_q;
    end
  end

  // cell store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.alive_out  = out_alive_q;
  assign res_o.generation = out_gen_q;

endmodule

[src/lgme_checker.sv]
// ----------------------------------------------------------------------------
// lgme_port_checks
// Port-level temporal checks for the Life grid engine, bound to the top level.
// ----------------------------------------------------------------------------
module lgme_port_checks (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_alive,
  input logic [lgme_pkg::GEN_W-1:0] out_generation
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_generation) && $stable(out_alive))
    else $error("result changed while stalled");

  // one transaction in flight: the request side closes right after acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // clearing pass follows reset
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready)
    else $error("request side open during clearing pass");

  // a result is presented only after the request side was closed
  a_result_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in progress");

endmodule

bind life_generation_mirror_edges lgme_port_checks u_lgme_port_checks (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (res_o.valid),
  .out_ready      (res_o.ready),
  .out_alive      (res_o.alive_out),
  .out_generation (res_o.generation)
);
